FILE: hw/rtl/nstp_pkg.sv
// ----------------------------------------------------------------------------
// nstp_pkg: shared types and constants for the settings text parser
// Transfer payloads, key matching codes, key text tables and defaults.
// ----------------------------------------------------------------------------
package nstp_pkg;

   localparam int LINE_STORE_DEF = 64;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic        address_mode;
      logic [31:0] host_address;
      logic [31:0] subnet_mask;
      logic [31:0] router_address;
      logic [31:0] resolver_address;
   } rsp_type;

   // key matching progress codes
   localparam logic [3:0] KP_START      = 4'd0;
   localparam logic [3:0] KP_MODE       = 4'd1;
   localparam logic [3:0] KP_MDHCP      = 4'd2;
   localparam logic [3:0] KP_MSTATIC    = 4'd3;
   localparam logic [3:0] KP_IP         = 4'd4;
   localparam logic [3:0] KP_MASK       = 4'd5;
   localparam logic [3:0] KP_GW         = 4'd6;
   localparam logic [3:0] KP_DNS        = 4'd7;
   localparam logic [3:0] KP_SET_DHCP   = 4'd8;
   localparam logic [3:0] KP_SET_STATIC = 4'd9;
   localparam logic [3:0] KP_VAL_IP     = 4'd10;
   localparam logic [3:0] KP_VAL_MASK   = 4'd11;
   localparam logic [3:0] KP_VAL_GW     = 4'd12;
   localparam logic [3:0] KP_VAL_DNS    = 4'd13;
   localparam logic [3:0] KP_NONE       = 4'd15;

   localparam logic [8*9-1:0]  KEY_DHCP   = "mode=dhcp";
   localparam logic [8*11-1:0] KEY_STATIC = "mode=static";
   localparam logic [8*3-1:0]  KEY_IP     = "ip=";
   localparam logic [8*8-1:0]  KEY_MASK   = "netmask=";
   localparam logic [8*8-1:0]  KEY_GW     = "gateway=";
   localparam logic [8*4-1:0]  KEY_DNS    = "dns=";

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_M = 8'h6D;
   localparam logic [7:0] CH_LOW_I = 8'h69;
   localparam logic [7:0] CH_LOW_N = 8'h6E;
   localparam logic [7:0] CH_LOW_G = 8'h67;
   localparam logic [7:0] CH_LOW_D = 8'h64;
   localparam logic [7:0] CH_LOW_S = 8'h73;

   localparam logic [7:0]  OCTET_MAX      = 8'd255;
   localparam logic [3:0]  MODE_PREFIX    = 4'd5;
   localparam logic [31:0] MASK_DEFAULT   = 32'hFFFF_FF00;
   localparam logic [31:0] RESOLV_DEFAULT = 32'h0808_0808;

   // length of the key matched in a progress state
   function automatic logic [3:0] key_len(input logic [3:0] kp);
      logic [3:0] len;
      unique case (kp)
         KP_MODE, KP_MDHCP: len = 4'd9;
         KP_MSTATIC:        len = 4'd11;
         KP_IP:             len = 4'd3;
         KP_MASK, KP_GW:    len = 4'd8;
         KP_DNS:            len = 4'd4;
         default:           len = 4'd0;
      endcase
      return len;
   endfunction

   // character of the key at position pos (pos below the key length)
   function automatic logic [7:0] key_char(input logic [3:0] kp, input logic [3:0] pos);
      logic [3:0] sel;
      logic [7:0] ch;
      sel = key_len(kp) - 4'd1 - pos;
      unique case (kp)
         KP_MODE, KP_MDHCP: ch = KEY_DHCP[{sel, 3'b000} +: 8];
         KP_MSTATIC:        ch = KEY_STATIC[{sel, 3'b000} +: 8];
         KP_IP:             ch = KEY_IP[{sel[1:0], 3'b000} +: 8];
         KP_MASK:           ch = KEY_MASK[{sel[2:0], 3'b000} +: 8];
         KP_GW:             ch = KEY_GW[{sel[2:0], 3'b000} +: 8];
         KP_DNS:            ch = KEY_DNS[{sel[1:0], 3'b000} +: 8];
         default:           ch = CH_NUL;
      endcase
      return ch;
   endfunction

   // progress code once the whole key has matched
   function automatic logic [3:0] key_done(input logic [3:0] kp);
      logic [3:0] nxt;
      unique case (kp)
         KP_MDHCP:   nxt = KP_SET_DHCP;
         KP_MSTATIC: nxt = KP_SET_STATIC;
         KP_IP:      nxt = KP_VAL_IP;
         KP_MASK:    nxt = KP_VAL_MASK;
         KP_GW:      nxt = KP_VAL_GW;
         KP_DNS:     nxt = KP_VAL_DNS;
         default:    nxt = KP_NONE;
      endcase
      return nxt;
   endfunction

endpackage

FILE: hw/rtl/network_settings_text_parser_unit.sv
// ----------------------------------------------------------------------------
// network_settings_text_parser_unit: streaming network settings parser
// Parses key=value lines byte by byte and reports the settings on the last
// byte of the text, then returns to the default settings.
// ----------------------------------------------------------------------------
// Throughput: one text byte per cycle while no stalled result blocks the input;
//   the per-byte parse step is one register-to-register pass (constant multiply
//   by ten, key compare). Result registered in the cycle after the end_of_text byte.
// Reset: clears the result valid flag and loads the default settings
//   (dhcp, netmask 255.255.255.0, dns 8.8.8.8) and an empty line.
// ----------------------------------------------------------------------------
module network_settings_text_parser_unit #(
   parameter int LINE_STORE = nstp_pkg::LINE_STORE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nstp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nstp_pkg::rsp_type rsp_data
);
   import nstp_pkg::*;

   localparam int LC_W = $clog2(LINE_STORE);
   localparam logic [LC_W-1:0] LINE_KEEP = LC_W'(LINE_STORE - 1);

   // settings
   logic        mode_ff, mode_in;
   logic [31:0] host_ff, host_in;
   logic [31:0] mask_ff, mask_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] resolver_ff, resolver_in;

   // line parse state
   logic [LC_W-1:0] line_count_ff, line_count_in;
   logic [3:0]      key_ff, key_in;
   logic [7:0]      octet_ff, octet_in;
   logic [1:0]      dot_ff, dot_in;
   logic            seen_ff, seen_in;
   logic            bad_ff, bad_in;
   logic [23:0]     octets_ff, octets_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // state after the byte is applied to the line
   logic [LC_W-1:0] lc_n;
   logic [3:0]      key_n;
   logic [7:0]      octet_n;
   logic [1:0]      dot_n;
   logic            seen_n;
   logic            bad_n;
   logic [23:0]     octets_n;

   // line state seen by the line close
   logic [3:0]  fin_key;
   logic [7:0]  fin_octet;
   logic [1:0]  fin_dot;
   logic        fin_seen;
   logic        fin_bad;
   logic [23:0] fin_octets;
   logic        fin_ok;
   logic [31:0] fin_addr;

   logic        take;
   logic        is_term;
   logic        do_finish;
   logic [7:0]  ch;
   logic [3:0]  klen;
   logic [11:0] digit_sum;
   logic        mode_f;
   logic [31:0] host_f, mask_f, router_f, resolver_f;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign take      = req_valid & ~req_stall;
   assign ch        = req_data.text_byte;
   assign is_term   = (ch == CH_LF) || (ch == CH_CR) || (ch == CH_NUL);
   assign klen      = key_len(key_ff);
   assign digit_sum = {octet_ff, 3'b000} + {3'b000, octet_ff, 1'b0}
                      + {8'd0, ch[3:0] - CH_ZERO[3:0]};

   // one character of a line
   always_comb begin
      lc_n     = line_count_ff;
      key_n    = key_ff;
      octet_n  = octet_ff;
      dot_n    = dot_ff;
      seen_n   = seen_ff;
      bad_n    = bad_ff;
      octets_n = octets_ff;
      if (line_count_ff < LINE_KEEP) begin
         lc_n = line_count_ff + LC_W'(1);
         unique case (key_ff)
            KP_START: begin
               priority if (ch == CH_LOW_M) key_n = KP_MODE;
               else if (ch == CH_LOW_I)     key_n = KP_IP;
               else if (ch == CH_LOW_N)     key_n = KP_MASK;
               else if (ch == CH_LOW_G)     key_n = KP_GW;
               else if (ch == CH_LOW_D)     key_n = KP_DNS;
               else                         key_n = KP_NONE;
            end
            KP_MODE: begin
               priority if (line_count_ff < LC_W'(MODE_PREFIX)) begin
                  if (key_char(key_ff, line_count_ff[3:0]) != ch) key_n = KP_NONE;
               end else if (ch == CH_LOW_D) begin
                  key_n = KP_MDHCP;
               end else if (ch == CH_LOW_S) begin
                  key_n = KP_MSTATIC;
               end else begin
                  key_n = KP_NONE;
               end
            end
            KP_MDHCP, KP_MSTATIC, KP_IP, KP_MASK, KP_GW, KP_DNS: begin
               priority if (line_count_ff >= LC_W'(klen)
                            || key_char(key_ff, line_count_ff[3:0]) != ch) begin
                  key_n = KP_NONE;
               end else if (line_count_ff + LC_W'(1) == LC_W'(klen)) begin
                  key_n = key_done(key_ff);
               end else begin
                  key_n = key_ff;
               end
            end
            KP_VAL_IP, KP_VAL_MASK, KP_VAL_GW, KP_VAL_DNS: begin
               if (!bad_ff) begin
                  priority if (ch >= CH_ZERO && ch <= CH_NINE) begin
                     if (digit_sum > {4'd0, OCTET_MAX}) begin
                        bad_n = 1'b1;
                     end else begin
                        octet_n = digit_sum[7:0];
                        seen_n  = 1'b1;
                     end
                  end else if (ch == CH_DOT) begin
                     if (!seen_ff || dot_ff == 2'd3) begin
                        bad_n = 1'b1;
                     end else begin
                        octets_n = {octets_ff[15:0], octet_ff};
                        dot_n    = dot_ff + 2'd1;
                        octet_n  = '0;
                        seen_n   = 1'b0;
                     end
                  end else begin
                     bad_n = 1'b1;
                  end
               end
            end
            default: begin
               key_n = key_ff;
            end
         endcase
      end
   end

   // line close: a terminator closes the stored line, the last byte the updated one
   always_comb begin
      fin_key    = is_term ? key_ff : key_n;
      fin_octet  = is_term ? octet_ff : octet_n;
      fin_dot    = is_term ? dot_ff : dot_n;
      fin_seen   = is_term ? seen_ff : seen_n;
      fin_bad    = is_term ? bad_ff : bad_n;
      fin_octets = is_term ? octets_ff : octets_n;
      fin_ok     = ~fin_bad & fin_seen & (fin_dot == 2'd3);
      fin_addr   = {fin_octets, fin_octet};
      do_finish  = is_term | req_data.end_of_text;

      mode_f     = mode_ff;
      host_f     = host_ff;
      mask_f     = mask_ff;
      router_f   = router_ff;
      resolver_f = resolver_ff;
      if (do_finish) begin
         unique case (fin_key)
            KP_SET_DHCP:   mode_f = 1'b0;
            KP_SET_STATIC: mode_f = 1'b1;
            KP_VAL_IP:     if (fin_ok) host_f = fin_addr;
            KP_VAL_MASK:   if (fin_ok) mask_f = fin_addr;
            KP_VAL_GW:     if (fin_ok) router_f = fin_addr;
            KP_VAL_DNS:    if (fin_ok) resolver_f = fin_addr;
            default:       mode_f = mode_ff;
         endcase
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      host_in       = host_ff;
      mask_in       = mask_ff;
      router_in     = router_ff;
      resolver_in   = resolver_ff;
      line_count_in = line_count_ff;
      key_in        = key_ff;
      octet_in      = octet_ff;
      dot_in        = dot_ff;
      seen_in       = seen_ff;
      bad_in        = bad_ff;
      octets_in     = octets_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      if (take) begin
         if (do_finish) begin
            line_count_in = '0;
            key_in        = KP_START;
            octet_in      = '0;
            dot_in        = '0;
            seen_in       = 1'b0;
            bad_in        = 1'b0;
            octets_in     = '0;
         end else begin
            line_count_in = lc_n;
            key_in        = key_n;
            octet_in      = octet_n;
            dot_in        = dot_n;
            seen_in       = seen_n;
            bad_in        = bad_n;
            octets_in     = octets_n;
         end
         if (req_data.end_of_text) begin
            // report, then go back to the defaults
            rsp_valid_in                 = 1'b1;
            rsp_data_in.address_mode     = mode_f;
            rsp_data_in.host_address     = host_f;
            rsp_data_in.subnet_mask      = mask_f;
            rsp_data_in.router_address   = router_f;
            rsp_data_in.resolver_address = resolver_f;
            mode_in                      = 1'b0;
            host_in                      = '0;
            mask_in                      = MASK_DEFAULT;
            router_in                    = '0;
            resolver_in                  = RESOLV_DEFAULT;
         end else begin
            mode_in     = mode_f;
            host_in     = host_f;
            mask_in     = mask_f;
            router_in   = router_f;
            resolver_in = resolver_f;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         host_ff       <= '0;
         mask_ff       <= MASK_DEFAULT;
         router_ff     <= '0;
         resolver_ff   <= RESOLV_DEFAULT;
         line_count_ff <= '0;
         key_ff        <= KP_START;
         octet_ff      <= '0;
         dot_ff        <= '0;
         seen_ff       <= 1'b0;
         bad_ff        <= 1'b0;
         octets_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         host_ff       <= host_in;
         mask_ff       <= mask_in;
         router_ff     <= router_in;
         resolver_ff   <= resolver_in;
         line_count_ff <= line_count_in;
         key_ff        <= key_in;
         octet_ff      <= octet_in;
         dot_ff        <= dot_in;
         seen_ff       <= seen_in;
         bad_ff        <= bad_in;
         octets_ff     <= octets_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/network_settings_text_parser_unit_test.sv
// ----------------------------------------------------------------------------
// network_settings_text_parser_unit_test: self-checking bench for the parser
// Streams settings texts byte by byte and tracks the parse state alongside
// the block. Every settings transfer is checked field by field against the
// settings predicted for the end of its text. The texts mix well-formed
// keys and addresses with broken ones, junk and overlong lines.
// ----------------------------------------------------------------------------
module network_settings_text_parser_unit_test;

   localparam int LINE_KEEP      = nstp_pkg::LINE_STORE_DEF - 1;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int QUIET_TAIL     = 150;

   localparam logic       MODE_DHCP   = 1'b0;
   localparam logic       MODE_STATIC = 1'b1;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_NUL    = 8'h00;

   typedef enum logic [3:0] {
      KS_START, KS_MODE, KS_MDHCP, KS_MSTATIC, KS_IP, KS_MASK, KS_GW, KS_DNS,
      KS_SET_DHCP, KS_SET_STATIC, KS_VAL_IP, KS_VAL_MASK, KS_VAL_GW, KS_VAL_DNS,
      KS_NONE
   } key_state_type;

   typedef enum int {
      FLAW_NONE, FLAW_FEW, FLAW_MANY, FLAW_BIG, FLAW_EMPTY, FLAW_STRAY
   } addr_flaw_type;

   typedef struct packed {
      logic              pause_first;
      nstp_pkg::req_type item;
   } queued_byte_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   nstp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   nstp_pkg::rsp_type rsp_data;

   queued_byte_type   text_stream_q[$];
   nstp_pkg::rsp_type settings_due_q[$];
   logic [7:0]        text_bytes_q[$];

   // predicted settings and line parse state
   nstp_pkg::rsp_type settings_now;
   key_state_type     line_key;
   int                line_len;
   int                octet_acc;
   int                dots;
   bit                have_digit;
   bit                addr_bad;
   logic [23:0]       octets_closed;

   int fail_count;
   int accepted_bytes;
   int total_bytes;
   int burst_start;
   int burst_end;
   int cycle_count;
   int stalled_cycles;
   bit byte_taken;
   int send_gap;
   int send_pct;
   int recv_gap;
   int recv_pct;
   int hold_left;
   bit hold_done;

   network_settings_text_parser_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void load_defaults();
      settings_now.address_mode     = MODE_DHCP;
      settings_now.host_address     = 32'h0;
      settings_now.subnet_mask      = 32'hFFFF_FF00;
      settings_now.router_address   = 32'h0;
      settings_now.resolver_address = 32'h0808_0808;
   endfunction

   function automatic void clear_parse();
      line_key      = KS_START;
      line_len      = 0;
      octet_acc     = 0;
      dots          = 0;
      have_digit    = 1'b0;
      addr_bad      = 1'b0;
      octets_closed = 24'h0;
   endfunction

   function automatic void close_line();
      bit          ok;
      logic [31:0] addr;
      ok   = !addr_bad && have_digit && (dots == 3);
      addr = {octets_closed, 8'(octet_acc)};
      case (line_key)
         KS_SET_DHCP:   settings_now.address_mode = MODE_DHCP;
         KS_SET_STATIC: settings_now.address_mode = MODE_STATIC;
         KS_VAL_IP:     if (ok) settings_now.host_address = addr;
         KS_VAL_MASK:   if (ok) settings_now.subnet_mask = addr;
         KS_VAL_GW:     if (ok) settings_now.router_address = addr;
         KS_VAL_DNS:    if (ok) settings_now.resolver_address = addr;
         default: ;
      endcase
      clear_parse();
   endfunction

   function automatic void match_key_char(input string key, input logic [7:0] c,
                                          input key_state_type done);
      if (line_len >= key.len() || key[line_len] != c) begin
         line_key = KS_NONE;
      end else if (line_len + 1 == key.len()) begin
         line_key = done;
      end
   endfunction

   function automatic void addr_char(input logic [7:0] c);
      int v;
      if (addr_bad) begin
         // keep rejecting the rest of the value
      end else if (c >= "0" && c <= "9") begin
         v = octet_acc * 10 + (c - "0");
         if (v > 255) begin
            addr_bad = 1'b1;
         end else begin
            octet_acc  = v;
            have_digit = 1'b1;
         end
      end else if (c == ".") begin
         if (!have_digit || dots >= 3) begin
            addr_bad = 1'b1;
         end else begin
            octets_closed = {octets_closed[15:0], 8'(octet_acc)};
            dots          = dots + 1;
            octet_acc     = 0;
            have_digit    = 1'b0;
         end
      end else begin
         addr_bad = 1'b1;
      end
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      case (line_key)
         KS_START: begin
            if (c == "m") line_key = KS_MODE;
            else if (c == "i") line_key = KS_IP;
            else if (c == "n") line_key = KS_MASK;
            else if (c == "g") line_key = KS_GW;
            else if (c == "d") line_key = KS_DNS;
            else line_key = KS_NONE;
         end
         KS_MODE: begin
            // shared "mode=" prefix, then split on the first value letter
            if (line_len < 5) match_key_char("mode=dhcp", c, KS_NONE);
            else if (c == "d") line_key = KS_MDHCP;
            else if (c == "s") line_key = KS_MSTATIC;
            else line_key = KS_NONE;
         end
         KS_MDHCP:   match_key_char("mode=dhcp", c, KS_SET_DHCP);
         KS_MSTATIC: match_key_char("mode=static", c, KS_SET_STATIC);
         KS_IP:      match_key_char("ip=", c, KS_VAL_IP);
         KS_MASK:    match_key_char("netmask=", c, KS_VAL_MASK);
         KS_GW:      match_key_char("gateway=", c, KS_VAL_GW);
         KS_DNS:     match_key_char("dns=", c, KS_VAL_DNS);
         KS_VAL_IP, KS_VAL_MASK, KS_VAL_GW, KS_VAL_DNS: addr_char(c);
         default: ;
      endcase
      line_len = line_len + 1;
   endfunction

   function automatic void predict_text_byte(input nstp_pkg::req_type t);
      if (t.text_byte == BYTE_LF || t.text_byte == BYTE_CR || t.text_byte == BYTE_NUL) begin
         close_line();
      end else if (line_len < LINE_KEEP) begin
         parse_char(t.text_byte);
      end
      if (t.end_of_text) begin
         close_line();
         settings_due_q.push_back(settings_now);
         load_defaults();
      end
   endfunction

   // ---------------------------------------------------------------- text builder

   function automatic void put_byte(input logic [7:0] b);
      text_bytes_q.push_back(b);
   endfunction

   function automatic void put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_bytes_q.push_back(s[i]);
   endfunction

   function automatic void put_line_end();
      case ($urandom_range(0, 5))
         0, 1, 2: put_byte(BYTE_LF);
         3:       put_byte(BYTE_CR);
         4:       put_byte(BYTE_NUL);
         default: begin
            put_byte(BYTE_CR);
            put_byte(BYTE_LF);
         end
      endcase
   endfunction

   // hand the built text to the sender, flagging its final byte
   function automatic void flush_text(input bit pause);
      queued_byte_type e;
      for (int i = 0; i < text_bytes_q.size(); i++) begin
         e.pause_first          = pause && (i == 0);
         e.item.text_byte       = text_bytes_q[i];
         e.item.end_of_text     = (i == text_bytes_q.size() - 1);
         text_stream_q.push_back(e);
      end
      text_bytes_q.delete();
   endfunction

   // truncate or misspell a key now and then
   function automatic string bent_key(input string key);
      int    pos;
      string s;
      s = key;
      if ($urandom_range(0, 99) < 15) begin
         pos = $urandom_range(0, key.len() - 1);
         if ($urandom_range(0, 1)) begin
            s = (pos == 0) ? "" : key.substr(0, pos - 1);
         end else begin
            s.putc(pos, byte'(8'h61 + $urandom_range(0, 25)));
         end
      end
      return s;
   endfunction

   function automatic string address_text();
      addr_flaw_type flaw;
      int            r;
      int            n;
      int            bad_at;
      int            v;
      logic [7:0]    b;
      string         s;
      string         part;
      r    = $urandom_range(0, 9);
      flaw = (r < 5) ? FLAW_NONE : addr_flaw_type'(r - 4);
      n    = (flaw == FLAW_FEW) ? 3 : (flaw == FLAW_MANY) ? 5 : 4;
      bad_at = $urandom_range(0, n - 1);
      s = "";
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0:       v = 0;
            1:       v = 255;
            default: v = $urandom_range(0, 255);
         endcase
         part = $sformatf("%0d", v);
         if ($urandom_range(0, 7) == 0) part = {"00", part};
         if (i == bad_at) begin
            case (flaw)
               FLAW_BIG:   part = $sformatf("%0d", $urandom_range(256, 9999));
               FLAW_EMPTY: part = "";
               FLAW_STRAY: begin
                  b = 8'($urandom_range(1, 255));
                  if ((b >= "0" && b <= "9") || b == "." || b == BYTE_LF || b == BYTE_CR)
                     b = "x";
                  part = {part, $sformatf("%c", b)};
               end
               default: ;
            endcase
         end
         s = (i == 0) ? part : {s, ".", part};
      end
      return s;
   endfunction

   function automatic string address_key();
      case ($urandom_range(0, 3))
         0:       return "ip=";
         1:       return "netmask=";
         2:       return "gateway=";
         default: return "dns=";
      endcase
   endfunction

   function automatic void make_line();
      int r;
      int z;
      r = $urandom_range(0, 99);
      if (r < 22) begin
         put_str(bent_key($urandom_range(0, 1) ? "mode=dhcp" : "mode=static"));
         if ($urandom_range(0, 2) == 0) put_str("_on X");
      end else if (r < 72) begin
         put_str(bent_key(address_key()));
         put_str(address_text());
      end else if (r < 77) begin
         // overlong line: leading zeros push the address toward the cut
         put_str(address_key());
         z = $urandom_range(40, 58);
         repeat (z) put_byte("0");
         put_str(address_text());
         put_str("tail");
      end else if (r < 90) begin
         repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void make_text(input bit pause);
      int lines;
      lines = $urandom_range(1, 4);
      for (int i = 0; i < lines; i++) begin
         make_line();
         if (i < lines - 1 || $urandom_range(0, 1)) put_line_end();
      end
      if (text_bytes_q.size() == 0) put_byte(BYTE_LF);
      flush_text(pause);
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 3;
         2:       return 15;
         default: return 40;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      $display("tb: [%0t] %s", $realtime, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin
      if (cycle_count % 200 == 0) send_pct = pick_rate();
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !byte_taken) begin
         // hold the stalled transfer
      end else if (send_gap > 0) begin
         send_gap = send_gap - 1;
         req_valid <= 1'b0;
      end else if (text_stream_q.size() == 0) begin
         req_valid <= 1'b0;
      end else if (text_stream_q[0].pause_first && settings_due_q.size() != 0) begin
         req_valid <= 1'b0;
      end else if (accepted_bytes + QUIET_TAIL < total_bytes
                   && !(accepted_bytes >= burst_start && accepted_bytes < burst_end)
                   && $urandom_range(0, 99) < send_pct) begin
         send_gap = $urandom_range(1, 14) - 1;
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_data  <= text_stream_q[0].item;
      end
   end

   always @(negedge clock) begin
      if (cycle_count % 200 == 0) recv_pct = pick_rate();
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_bytes >= burst_start) begin
         // long hold-off so the short texts back up into the input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap = recv_gap - 1;
         rsp_stall <= 1'b1;
      end else if (accepted_bytes + QUIET_TAIL < total_bytes
                   && $urandom_range(0, 99) < recv_pct) begin
         recv_gap = $urandom_range(1, 14) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      nstp_pkg::rsp_type want;
      bit                rsp_taken;
      cycle_count = cycle_count + 1;
      byte_taken  = 1'b0;
      rsp_taken   = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         predict_text_byte(req_data);
         void'(text_stream_q.pop_front());
         accepted_bytes = accepted_bytes + 1;
         byte_taken     = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         if (settings_due_q.size() == 0) begin
            report_mismatch("settings transfer with nothing pending");
         end else begin
            want = settings_due_q.pop_front();
            check_field("address_mode", 32'(rsp_data.address_mode), 32'(want.address_mode));
            check_field("host_address", rsp_data.host_address, want.host_address);
            check_field("subnet_mask", rsp_data.subnet_mask, want.subnet_mask);
            check_field("router_address", rsp_data.router_address, want.router_address);
            check_field("resolver_address", rsp_data.resolver_address,
                        want.resolver_address);
         end
      end
      stalled_cycles = (byte_taken || rsp_taken) ? 0 : stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      fail_count     = 0;
      accepted_bytes = 0;
      cycle_count    = 0;
      stalled_cycles = 0;
      byte_taken     = 1'b0;
      send_gap       = 0;
      recv_gap       = 0;
      send_pct       = 0;
      recv_pct       = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      load_defaults();
      clear_parse();

      // directed: lone terminator, lone 0xFF, bare last address, mode with tail
      put_byte(BYTE_NUL);
      flush_text(1'b0);
      put_byte(8'hFF);
      flush_text(1'b0);
      put_str("dns=9.9.9.9");
      flush_text(1'b0);
      put_str("mode=staticX");
      put_byte(BYTE_CR);
      flush_text(1'b0);

      while (text_stream_q.size() < 300) make_text($urandom_range(0, 19) == 0);

      // run of tiny texts, sent while the receiver holds off
      burst_start = text_stream_q.size();
      repeat (40) begin
         repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
         flush_text(1'b0);
      end
      burst_end = text_stream_q.size();

      make_text(1'b1);
      while (text_stream_q.size() < 975) make_text($urandom_range(0, 19) == 0);
      total_bytes = text_stream_q.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_stream_q.size() != 0 || settings_due_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (settings_due_q.size() != 0)
         report_mismatch($sformatf("%0d settings never arrived", settings_due_q.size()));

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
